// ----- rtl/core/ring_fifo_with_drain_defines.svh -----
// Assertion macros for the ring FIFO checker.
// Needs clk and rst in the scope where a macro is used.
`ifndef RING_FIFO_WITH_DRAIN_DEFINES_SVH
`define RING_FIFO_WITH_DRAIN_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset
`define RFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/rfd_pkg.sv -----
// Shared types and constants for the ring FIFO with drain.
// No dependencies; imported by every module of the block.
`default_nettype none

package rfd_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);

  // Fixed field widths of the ports
  localparam int CAP_W  = 5;
  localparam int ROOM_W = 5;
  localparam int WORD_W = 32;
  localparam int FILL_W = 5;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_GET   = 2'd1,
    OP_DRAIN = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_ROOM  = 2'd3
  } status_t;

  typedef struct packed {
    op_t                 operation;
    logic [WORD_W-1:0]   data_in;
    logic [ROOM_W-1:0]   drain_room;
  } in_item_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   data_out;
    logic                last;
    logic [FILL_W-1:0]   fill_level;
    logic                empty_flag;
    logic                full_flag;
    logic [FILL_W-1:0]   drained_number;
  } out_item_t;

  // Request to the entry store
  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [PTR_W-1:0]      raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/core/rfd_store.sv -----
// Entry store of the ring FIFO: one write and one registered read port.
// Depends on rfd_pkg for depth, widths and the request struct.
`default_nettype none

module rfd_store import rfd_pkg::*; (
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  // Write on request, registered read; rdata holds otherwise
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rfd_ctrl.sv -----
// Sequencer of the ring FIFO: pointers, fill count, capacity and the result register.
// Depends on rfd_pkg; drives the entry store in rfd_store.
`default_nettype none

module rfd_ctrl import rfd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_write,
  input  logic [CAP_W-1:0]      cfg_data,
  output mem_req_t              mem_req,
  input  logic [DATA_WIDTH-1:0] rdata
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DATA = 3'b100
  } state_t;

  state_t              state, state_next;
  op_t                 op, op_next;
  logic [WORD_W-1:0]   word, word_next;
  logic [ROOM_W-1:0]   room, room_next;
  logic [CAP_W-1:0]    capacity, capacity_next;
  logic [PTR_W-1:0]    rd_ptr, rd_ptr_next;
  logic [PTR_W-1:0]    wr_ptr, wr_ptr_next;
  logic [CNT_W-1:0]    fill, fill_next;
  logic [CNT_W-1:0]    total, total_next;
  logic [CNT_W-1:0]    cap_use;
  logic [CNT_W-1:0]    emit_fill;
  logic                out_free;
  logic                emit;
  out_item_t           emit_item;

  // Step a pointer, wrapping at the capacity in use
  function automatic logic [PTR_W-1:0] step_ptr(input logic [PTR_W-1:0] p,
                                                input logic [CNT_W-1:0] lim);
    logic [CNT_W:0] n;
    n = (CNT_W+1)'(p) + (CNT_W+1)'(1);
    return (n >= (CNT_W+1)'(lim)) ? '0 : PTR_W'(n);
  endfunction

  // Clamp the capacity register to 1..DEPTH
  always_comb begin
    if (capacity == '0) begin
      cap_use = CNT_W'(1);
    end else if (int'(capacity) > DEPTH) begin
      cap_use = CNT_W'(DEPTH);
    end else begin
      cap_use = CNT_W'(capacity);
    end
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Sequence one item: accept, execute, stream popped words
  always_comb begin
    state_next    = state;
    op_next       = op;
    word_next     = word;
    room_next     = room;
    capacity_next = capacity;
    rd_ptr_next   = rd_ptr;
    wr_ptr_next   = wr_ptr;
    fill_next     = fill;
    total_next    = total;
    mem_req       = '0;
    emit          = 1'b0;
    emit_item     = '0;
    emit_item.last = 1'b1;
    emit_item.status = ST_OK;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op_next    = in_data.operation;
          word_next  = in_data.data_in;
          room_next  = in_data.drain_room;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          unique case (op) inside
            OP_PUT: begin
              emit       = 1'b1;
              state_next = S_IDLE;
              if (fill >= cap_use) begin
                emit_item.status = ST_FULL;
              end else begin
                mem_req.we    = 1'b1;
                mem_req.waddr = wr_ptr;
                mem_req.wdata = DATA_WIDTH'(word);
                wr_ptr_next   = step_ptr(wr_ptr, cap_use);
                fill_next     = fill + CNT_W'(1);
              end
            end
            OP_GET, OP_DRAIN: begin
              if (fill == '0) begin
                emit             = 1'b1;
                emit_item.status = ST_EMPTY;
                state_next       = S_IDLE;
              end else if (op == OP_DRAIN && int'(room) < int'(fill)) begin
                emit             = 1'b1;
                emit_item.status = ST_ROOM;
                state_next       = S_IDLE;
              end else begin
                // Pop the first word; data arrives next cycle
                mem_req.re  = 1'b1;
                mem_req.raddr = rd_ptr;
                rd_ptr_next = step_ptr(rd_ptr, cap_use);
                fill_next   = fill - CNT_W'(1);
                total_next  = fill;
                state_next  = S_DATA;
              end
            end
            OP_CLEAR: begin
              rd_ptr_next = '0;
              wr_ptr_next = '0;
              fill_next   = '0;
              emit        = 1'b1;
              state_next  = S_IDLE;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_DATA: begin
        if (out_free) begin
          emit               = 1'b1;
          emit_item.data_out = WORD_W'(rdata);
          if (op == OP_DRAIN && fill != '0) begin
            // Deliver this word and fetch the next one
            emit_item.last = 1'b0;
            mem_req.re     = 1'b1;
            mem_req.raddr  = rd_ptr;
            rd_ptr_next    = step_ptr(rd_ptr, cap_use);
            fill_next      = fill - CNT_W'(1);
          end else begin
            if (op == OP_DRAIN) begin
              emit_item.drained_number = FILL_W'(total);
            end
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase

    // Flags reflect the fill level after this result; a streamed word was
    // already counted out when it was fetched
    emit_fill = (state == S_DATA) ? fill : fill_next;
    emit_item.fill_level = FILL_W'(emit_fill);
    emit_item.empty_flag = (emit_fill == '0);
    emit_item.full_flag  = (emit_fill == cap_use);

    // Capacity write empties the buffer
    if (cfg_write) begin
      capacity_next = cfg_data;
      rd_ptr_next   = '0;
      wr_ptr_next   = '0;
      fill_next     = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAP_W'(DEPTH);
      rd_ptr   <= '0;
      wr_ptr   <= '0;
      fill     <= '0;
      total    <= '0;
    end else begin
      state    <= state_next;
      capacity <= capacity_next;
      rd_ptr   <= rd_ptr_next;
      wr_ptr   <= wr_ptr_next;
      fill     <= fill_next;
      total    <= total_next;
    end
  end

  // Latched item payload
  always_ff @(posedge clk) begin
    op   <= op_next;
    word <= word_next;
    room <= room_next;
  end

  // Result register: load on emit, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ring_fifo_with_drain.sv -----
// Ring FIFO with drain: a put, get, drain or clear per input transfer.
// Sequence: an item is latched while idle, then executed; put, clear and refused items
// load their result from the execute step, a get or drain first reads the store and
// delivers its first word from the data step, later drain words follow each cycle
// while the output is not stalled. One item at a time: in_stall is high until it is done.
// Reset (sync, rst high) empties the buffer and sets capacity to 16; the store is not cleared.
`default_nettype none

module ring_fifo_with_drain import rfd_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_write,
  input  logic [CAP_W-1:0] cfg_data
);

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] rdata;

  // Sequencer with result register
  rfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .mem_req   (mem_req),
    .rdata     (rdata)
  );

  // Entry store
  rfd_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

endmodule

`default_nettype wire

// ----- rtl/core/rfd_checker.sv -----
// Port-level checker for the ring FIFO, bound to the top level.
// Depends on rfd_pkg and the assertion macros in ring_fifo_with_drain_defines.svh.
`default_nettype none
`include "ring_fifo_with_drain_defines.svh"

module rfd_checker import rfd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // Hold a stalled result
  `RFD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // Empty flag tracks the fill level
  `RFD_ASSERT_IMP(a_empty_flag, out_valid, out_data.empty_flag == (out_data.fill_level == '0), "empty flag mismatch")

  // Only a successful drain word may be non-final, and it reports no count
  `RFD_ASSERT_IMP(a_mid_drain, out_valid && !out_data.last, out_data.status == ST_OK && out_data.drained_number == '0 && !out_data.empty_flag, "bad non-final result")

  // A refused item returns no data
  `RFD_ASSERT_IMP(a_refused, out_valid && out_data.status != ST_OK, out_data.last && out_data.data_out == '0 && out_data.drained_number == '0, "bad refused result")

endmodule

bind ring_fifo_with_drain rfd_checker u_rfd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// ----- test/ring_fifo_with_drain_test.sv -----
// Self-checking testbench for ring_fifo_with_drain: directed and random put/get/drain/clear
// traffic under several capacity settings and pacing modes, checked against an in-bench model.
// Depends on rfd_pkg and the ring_fifo_with_drain RTL only.
`default_nettype none

module ring_fifo_with_drain_test import rfd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum int {PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH} pace_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_item_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_item_t        out_data;
  logic             cfg_write = 1'b0;
  logic [CAP_W-1:0] cfg_data = '0;

  // Stimulus and scoreboard
  in_item_t  queued_items[$];
  out_item_t due_results[$];
  logic      in_fire = 1'b0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        errors = 0;

  // Shadow FIFO state
  logic [WORD_W-1:0] word_mem [DEPTH];
  int                rd_ptr;
  int                wr_ptr;
  int                level;
  logic [CAP_W-1:0]  cap_reg;

  ring_fifo_with_drain u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic int cap_in_use(logic [CAP_W-1:0] c);
    if (c == 0) return 1;
    if (c > DEPTH) return DEPTH;
    return c;
  endfunction

  function automatic int step_ptr(int p);
    return (p + 1 >= cap_in_use(cap_reg)) ? 0 : p + 1;
  endfunction

  task automatic post_result(status_t st, logic [WORD_W-1:0] word, logic fin,
                             logic [FILL_W-1:0] drained);
    out_item_t r;
    r.status         = st;
    r.data_out       = word;
    r.last           = fin;
    r.fill_level     = FILL_W'(level);
    r.empty_flag     = (level == 0);
    r.full_flag      = (level == cap_in_use(cap_reg));
    r.drained_number = drained;
    due_results.push_back(r);
  endtask

  // Advance the shadow FIFO by one operation and queue the results it causes
  task automatic apply_fifo_op(in_item_t it);
    int                total;
    logic [WORD_W-1:0] w;
    case (it.operation)
      OP_PUT: begin
        if (level >= cap_in_use(cap_reg)) begin
          post_result(ST_FULL, '0, 1'b1, '0);
        end else begin
          word_mem[wr_ptr] = it.data_in;
          wr_ptr = step_ptr(wr_ptr);
          level++;
          post_result(ST_OK, '0, 1'b1, '0);
        end
      end
      OP_GET: begin
        if (level == 0) begin
          post_result(ST_EMPTY, '0, 1'b1, '0);
        end else begin
          w = word_mem[rd_ptr];
          rd_ptr = step_ptr(rd_ptr);
          level--;
          post_result(ST_OK, w, 1'b1, '0);
        end
      end
      OP_DRAIN: begin
        total = level;
        if (total == 0) begin
          post_result(ST_EMPTY, '0, 1'b1, '0);
        end else if (it.drain_room < total) begin
          post_result(ST_ROOM, '0, 1'b1, '0);
        end else begin
          for (int i = 0; i < total; i++) begin
            w = word_mem[rd_ptr];
            rd_ptr = step_ptr(rd_ptr);
            level--;
            post_result(ST_OK, w, i + 1 == total,
                        (i + 1 == total) ? FILL_W'(total) : '0);
          end
        end
      end
      OP_CLEAR: begin
        rd_ptr = 0;
        wr_ptr = 0;
        level  = 0;
        post_result(ST_OK, '0, 1'b1, '0);
      end
    endcase
  endtask

  task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] seen);
    if (seen !== want) begin
      errors++;
      if (errors <= 10) $display("mismatch on %s: expected %0h, got %0h", name, want, seen);
    end
  endtask

  // Monitor: track reset, register writes and input transfers, check output transfers
  always @(posedge clk) begin
    out_item_t want;
    in_fire <= in_valid && !in_stall && !rst;
    if (rst) begin
      cap_reg = CAP_W'(DEPTH);
      rd_ptr  = 0;
      wr_ptr  = 0;
      level   = 0;
    end else begin
      if (cfg_write) begin
        cap_reg = cfg_data;
        rd_ptr  = 0;
        wr_ptr  = 0;
        level   = 0;
      end
      if (in_valid && !in_stall) apply_fifo_op(in_data);
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result transfer: %p", out_data);
        end else begin
          want = due_results.pop_front();
          check_field("status", want.status, out_data.status);
          check_field("data_out", want.data_out, out_data.data_out);
          check_field("last", want.last, out_data.last);
          check_field("fill_level", want.fill_level, out_data.fill_level);
          check_field("empty_flag", want.empty_flag, out_data.empty_flag);
          check_field("full_flag", want.full_flag, out_data.full_flag);
          check_field("drained_number", want.drained_number, out_data.drained_number);
        end
      end
    end
  end

  // Driver: randomize the output stall; hold a stalled item, otherwise present the next one or idle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_fire)) begin
      if (queued_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_data  <= queued_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  task automatic push_item(op_t op, logic [WORD_W-1:0] word, logic [ROOM_W-1:0] room);
    in_item_t it;
    it.operation  = op;
    it.data_in    = word;
    it.drain_room = room;
    queued_items.push_back(it);
  endtask

  // Mostly fill-then-empty sequences with random content, some loose noise
  task automatic queue_sequences(int count, int cap_use);
    int added;
    int k;
    int j;
    int r;
    added = 0;
    while (added < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_item(op_t'(2'($urandom_range(0, 3))), $urandom(),
                  ROOM_W'($urandom_range(0, 16)));
        added++;
      end else begin
        k = $urandom_range(1, cap_use + 1);
        repeat (k) push_item(OP_PUT, $urandom(), ROOM_W'($urandom_range(0, 16)));
        added += k;
        r = $urandom_range(0, 99);
        if (r < 55) begin
          push_item(OP_DRAIN, $urandom(), (r < 40) ? ROOM_W'($urandom_range(cap_use, 16))
                                                   : ROOM_W'($urandom_range(0, 16)));
          added++;
        end else if (r < 90) begin
          j = $urandom_range(1, k + 1);
          repeat (j) push_item(OP_GET, $urandom(), ROOM_W'($urandom_range(0, 16)));
          added += j;
        end else begin
          push_item(OP_CLEAR, $urandom(), ROOM_W'($urandom_range(0, 16)));
          added++;
        end
      end
    end
  endtask

  task automatic set_pace(pace_t p);
    case (p)
      PACE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      PACE_SEND: begin send_idle_pct = 65; recv_stall_pct = 0;  end
      PACE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 65; end
      PACE_BOTH: begin send_idle_pct = 8;  recv_stall_pct = 8;  end
    endcase
  endtask

  // Hold until every item is sent and every result is back, then let the pipe settle
  task automatic wait_quiet();
    int spins;
    spins = 0;
    @(posedge clk);
    while ((queued_items.size() != 0 || in_valid || due_results.size() != 0)
           && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    repeat (10) @(posedge clk);
  endtask

  task automatic set_capacity(logic [CAP_W-1:0] v);
    wait_quiet();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [CAP_W-1:0] mid_cap;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Full-size buffer after reset: empty refusals, word extremes, short drain room, clear
    set_pace(PACE_NONE);
    push_item(OP_GET,   32'h0000_0000, 5'd0);
    push_item(OP_DRAIN, 32'hFFFF_FFFF, 5'd16);
    push_item(OP_PUT,   32'h0000_0000, 5'd0);
    push_item(OP_PUT,   32'hFFFF_FFFF, 5'd16);
    push_item(OP_GET,   32'h0000_0000, 5'd0);
    push_item(OP_PUT,   32'h1234_5678, 5'd0);
    push_item(OP_DRAIN, 32'h0000_0000, 5'd1);
    push_item(OP_DRAIN, 32'h0000_0000, 5'd16);
    push_item(OP_CLEAR, 32'h0000_0000, 5'd0);
    push_item(OP_PUT,   32'hA5A5_A5A5, 5'd0);
    push_item(OP_CLEAR, 32'hFFFF_FFFF, 5'd16);

    // Zero capacity behaves as one entry: full refusal, drain of exactly one
    set_capacity(5'd0);
    push_item(OP_PUT,   32'hDEAD_BEEF, 5'd0);
    push_item(OP_PUT,   32'h0BAD_F00D, 5'd0);
    push_item(OP_GET,   32'h0000_0000, 5'd0);
    push_item(OP_GET,   32'h0000_0000, 5'd0);
    push_item(OP_PUT,   32'hCAFE_0001, 5'd0);
    push_item(OP_DRAIN, 32'h0000_0000, 5'd0);
    push_item(OP_DRAIN, 32'h0000_0000, 5'd1);
    push_item(OP_PUT,   32'h5555_AAAA, 5'd0);
    push_item(OP_CLEAR, 32'h0000_0000, 5'd0);

    // Capacity above the store size is limited to the store size
    set_capacity(5'd20);
    push_item(OP_PUT,   32'h8000_0001, 5'd0);
    push_item(OP_PUT,   32'h7FFF_FFFE, 5'd0);
    push_item(OP_DRAIN, 32'h0000_0000, 5'd16);

    // Random phases over capacity settings and pacing modes
    set_capacity(5'd16);
    set_pace(PACE_SEND);
    queue_sequences(12, 16);

    set_capacity(5'd1);
    set_pace(PACE_RECV);
    queue_sequences(12, 1);

    // Pause the sender until all results are in, keep the setting
    wait_quiet();
    set_pace(PACE_BOTH);
    queue_sequences(12, 1);

    mid_cap = CAP_W'($urandom_range(2, 15));
    set_capacity(mid_cap);
    set_pace(PACE_NONE);
    queue_sequences(12, cap_in_use(mid_cap));

    set_capacity(5'd31);
    set_pace(PACE_BOTH);
    queue_sequences(12, DEPTH);

    mid_cap = CAP_W'($urandom_range(2, 15));
    set_capacity(mid_cap);
    set_pace(PACE_RECV);
    queue_sequences(12, cap_in_use(mid_cap));

    wait_quiet();
    repeat (20) @(posedge clk);
    errors += due_results.size();
    if (errors == 0) begin
      $display("ring_fifo_with_drain_test: done, clean");
    end else begin
      $display("ring_fifo_with_drain_test: done, errors");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("ring_fifo_with_drain_test: done, errors");
    $finish;
  end

endmodule

`default_nettype wire
